[hdl/prd_pkg.sv]
// package for the primary ray direction block
// widths, pipeline stage numbering, register indexes and payload carry types
// no dependencies
`default_nettype none

package prd_pkg;

   // output component width, signed q1.(COMPONENT_WIDTH-1)
   localparam int COMPONENT_WIDTH = 16;

   // input and register lane widths
   localparam int LANE_W   = 16;
   localparam int REG_W    = 48;
   localparam int SCALE_W  = 16;
   localparam int CSR_IDX_W = 3;

   // arithmetic widths through the pipe
   localparam int PROD_W    = 33;            // screen coordinate times scale
   localparam int LPROD_W   = 49;            // lane times scaled coordinate
   localparam int ACC_W     = 50;            // exact three-term sum
   localparam int FWD_SHIFT = 27;
   localparam int SUM_SHIFT = 21;
   localparam int SUM_W     = 26;            // saturated sum, q.20 in [-32,32)
   localparam int MAG_W     = 26;
   localparam int SQ_W      = 51;
   localparam int LEN_W     = 52;
   localparam int LEN_SHIFT = 10;
   localparam int RAD_W     = 63;
   localparam int ROOT_ITER = 32;
   localparam int ROOT_W    = 32;
   localparam int REM_W     = 33;
   localparam int EXTRA_BITS = 5;

   // pipeline stage numbering
   localparam int ST_PX      = 0;
   localparam int ST_PROD    = 1;
   localparam int ST_SUM     = 2;
   localparam int ST_SQ      = 3;
   localparam int ST_LEN     = 4;
   localparam int ST_ROOT0   = 5;
   localparam int ST_DIV0    = ST_ROOT0 + ROOT_ITER;
   localparam int ST_OUT     = ST_DIV0 + COMPONENT_WIDTH;
   localparam int NUM_STAGES = ST_OUT + 1;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FORWARD = 3'd0,
      CSR_RIGHT   = 3'd1,
      CSR_UP      = 3'd2,
      CSR_HSCALE  = 3'd3,
      CSR_VSCALE  = 3'd4
   } csr_index_type;

   // per-word side data carried along the root and divide stages
   typedef struct packed {
      logic [2:0]             neg;
      logic [2:0][MAG_W-1:0]  mag;
      logic                   zero;
   } carry_type;

endpackage

`default_nettype wire

[hdl/prd_req_if.sv]
// request channel carrying one screen point per word
// depends on prd_pkg
`default_nettype none

interface prd_req_if import prd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [LANE_W-1:0] screen_x;
   logic signed [LANE_W-1:0] screen_y;

   modport source (output valid, output screen_x, output screen_y, input ready);
   modport sink   (input valid, input screen_x, input screen_y, output ready);
endinterface

`default_nettype wire

[hdl/prd_rsp_if.sv]
// response channel carrying one unit ray direction per word
// depends on prd_pkg
`default_nettype none

interface prd_rsp_if import prd_pkg::*; ();
   logic                              valid;
   logic                              ready;
   logic signed [COMPONENT_WIDTH-1:0] dir_i;
   logic signed [COMPONENT_WIDTH-1:0] dir_j;
   logic signed [COMPONENT_WIDTH-1:0] dir_k;
   logic                              zero_length;

   modport source (output valid, output dir_i, output dir_j, output dir_k,
                   output zero_length, input ready);
   modport sink   (input valid, input dir_i, input dir_j, input dir_k,
                   input zero_length, output ready);
endinterface

`default_nettype wire

[hdl/primary_ray_direction.sv]
// throughput: one word per cycle when the receiver is ready; set by the 32 one-step
// square root stages and the one-quotient-bit-per-stage dividers, all fully pipelined
// each stage moves on when it is empty or its successor moves, so bubbles close up
// reset (synchronous, active high) empties the pipe and loads the default camera
// depends on prd_pkg, prd_req_if, prd_rsp_if
`default_nettype none

module primary_ray_direction import prd_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   prd_req_if.sink                   req_word,
   prd_rsp_if.source                 rsp_word,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [REG_W-1:0]     csr_write_data
);

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SUM_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(64'sd1 <<< (SUM_W - 1));
   localparam logic [COMPONENT_WIDTH-1:0] DIR_MAX = {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};

   // configuration registers
   logic [REG_W-1:0]   forward_ff, right_ff, up_ff;
   logic [SCALE_W-1:0] hscale_ff, vscale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         forward_ff <= REG_W'(64'd16384);
         right_ff   <= REG_W'(64'd16384 << 32);
         up_ff      <= REG_W'(64'd16384 << 16);
         hscale_ff  <= SCALE_W'(4096);
         vscale_ff  <= SCALE_W'(4096);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FORWARD: forward_ff <= csr_write_data;
            CSR_RIGHT:   right_ff   <= csr_write_data;
            CSR_UP:      up_ff      <= csr_write_data;
            CSR_HSCALE:  hscale_ff  <= csr_write_data[SCALE_W-1:0];
            CSR_VSCALE:  vscale_ff  <= csr_write_data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // stage valids and stall chain
   logic [NUM_STAGES-1:0] valid_ff, valid_in, stage_en;

   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_word.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   assign valid_in       = {valid_ff[NUM_STAGES-2:0], req_word.valid};
   assign req_word.ready = stage_en[ST_PX];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (stage_en[k]) valid_ff[k] <= valid_in[k];
         end
      end
   end

   // scale the screen point
   logic signed [PROD_W-1:0] px_ff, py_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_PX]) begin
         px_ff <= req_word.screen_x * $signed({1'b0, hscale_ff});
         py_ff <= req_word.screen_y * $signed({1'b0, vscale_ff});
      end
   end

   // lane products with the right and up vectors
   logic signed [LANE_W-1:0]  fwd_ff   [3];
   logic signed [LPROD_W-1:0] rprod_ff [3];
   logic signed [LPROD_W-1:0] uprod_ff [3];

   always_ff @(posedge clock) begin
      if (stage_en[ST_PROD]) begin
         for (int n = 0; n < 3; n++) begin
            fwd_ff[n]   <= $signed(forward_ff[(2-n)*LANE_W +: LANE_W]);
            rprod_ff[n] <= $signed(right_ff[(2-n)*LANE_W +: LANE_W]) * px_ff;
            uprod_ff[n] <= $signed(up_ff[(2-n)*LANE_W +: LANE_W]) * py_ff;
         end
      end
   end

   // three-term sum, floor to q.20 and saturate
   logic signed [SUM_W-1:0] sum_ff [3];
   logic signed [SUM_W-1:0] sum_in [3];

   always_comb begin
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] sh;
      for (int n = 0; n < 3; n++) begin
         acc = (ACC_W'(fwd_ff[n]) <<< FWD_SHIFT) + ACC_W'(rprod_ff[n])
             + ACC_W'(uprod_ff[n]);
         sh  = acc >>> SUM_SHIFT;
         if (sh > SAT_HI)      sum_in[n] = SUM_W'(SAT_HI);
         else if (sh < SAT_LO) sum_in[n] = SUM_W'(SAT_LO);
         else                  sum_in[n] = SUM_W'(sh);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_SUM]) begin
         for (int n = 0; n < 3; n++) sum_ff[n] <= sum_in[n];
      end
   end

   // squares, signs and magnitudes
   logic [SQ_W-1:0] sq_ff [3];
   carry_type       sq_carry_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_SQ]) begin
         for (int n = 0; n < 3; n++) begin
            sq_ff[n]           <= SQ_W'(sum_ff[n] * sum_ff[n]);
            sq_carry_ff.neg[n] <= sum_ff[n][SUM_W-1];
            sq_carry_ff.mag[n] <= sum_ff[n][SUM_W-1] ? MAG_W'(-sum_ff[n])
                                                     : MAG_W'(sum_ff[n]);
         end
         sq_carry_ff.zero <= 1'b0;
      end
   end

   // squared length, scaled for the root
   logic [LEN_W-1:0] len_sum;
   logic [RAD_W-1:0] len_rad_ff;
   carry_type        len_carry_ff;

   assign len_sum = LEN_W'(sq_ff[0]) + LEN_W'(sq_ff[1]) + LEN_W'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (stage_en[ST_LEN]) begin
         len_rad_ff        <= RAD_W'(len_sum) << LEN_SHIFT;
         len_carry_ff.neg  <= sq_carry_ff.neg;
         len_carry_ff.mag  <= sq_carry_ff.mag;
         len_carry_ff.zero <= (len_sum == '0);
      end
   end

   // integer square root, one iteration per stage
   logic [RAD_W-1:0] rad_ff   [ROOT_ITER];
   logic [RAD_W-1:0] res_ff   [ROOT_ITER];
   carry_type        rcarry_ff[ROOT_ITER];

   for (genvar k = 0; k < ROOT_ITER; k++) begin : g_root
      localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (ROOT_ITER - 1 - k));
      logic [RAD_W-1:0] rad_prev, res_prev, trial;
      carry_type        carry_prev;

      if (k == 0) begin : g_first
         assign rad_prev   = len_rad_ff;
         assign res_prev   = '0;
         assign carry_prev = len_carry_ff;
      end else begin : g_next
         assign rad_prev   = rad_ff[k-1];
         assign res_prev   = res_ff[k-1];
         assign carry_prev = rcarry_ff[k-1];
      end

      assign trial = res_prev + BIT;

      always_ff @(posedge clock) begin
         if (stage_en[ST_ROOT0 + k]) begin
            if (rad_prev >= trial) begin
               rad_ff[k] <= rad_prev - trial;
               res_ff[k] <= (res_prev >> 1) + BIT;
            end else begin
               rad_ff[k] <= rad_prev;
               res_ff[k] <= res_prev >> 1;
            end
            rcarry_ff[k] <= carry_prev;
         end
      end
   end

   // restoring divide of each magnitude by the root, one quotient bit per stage
   logic [REM_W-1:0]           rem_ff  [COMPONENT_WIDTH][3];
   logic [COMPONENT_WIDTH-1:0] quo_ff  [COMPONENT_WIDTH][3];
   logic [ROOT_W-1:0]          root_ff [COMPONENT_WIDTH];
   carry_type                  dcarry_ff[COMPONENT_WIDTH];

   for (genvar j = 0; j < COMPONENT_WIDTH; j++) begin : g_div
      logic [REM_W-1:0]           rem_prev [3];
      logic [COMPONENT_WIDTH-1:0] quo_prev [3];
      logic [ROOT_W-1:0]          root_prev;
      carry_type                  carry_prev;

      if (j == 0) begin : g_first
         always_comb begin
            for (int n = 0; n < 3; n++) begin
               rem_prev[n] = REM_W'(rcarry_ff[ROOT_ITER-1].mag[n]) << (EXTRA_BITS - 1);
               quo_prev[n] = '0;
            end
         end
         assign root_prev  = res_ff[ROOT_ITER-1][ROOT_W-1:0];
         assign carry_prev = rcarry_ff[ROOT_ITER-1];
      end else begin : g_next
         always_comb begin
            for (int n = 0; n < 3; n++) begin
               rem_prev[n] = rem_ff[j-1][n];
               quo_prev[n] = quo_ff[j-1][n];
            end
         end
         assign root_prev  = root_ff[j-1];
         assign carry_prev = dcarry_ff[j-1];
      end

      always_ff @(posedge clock) begin
         logic [REM_W-1:0] t;
         if (stage_en[ST_DIV0 + j]) begin
            for (int n = 0; n < 3; n++) begin
               t = {rem_prev[n][REM_W-2:0], 1'b0};
               if (t >= {1'b0, root_prev}) begin
                  rem_ff[j][n] <= t - {1'b0, root_prev};
                  quo_ff[j][n] <= {quo_prev[n][COMPONENT_WIDTH-2:0], 1'b1};
               end else begin
                  rem_ff[j][n] <= t;
                  quo_ff[j][n] <= {quo_prev[n][COMPONENT_WIDTH-2:0], 1'b0};
               end
            end
            root_ff[j]   <= root_prev;
            dcarry_ff[j] <= carry_prev;
         end
      end
   end

   // sign, saturation and zero-length override
   logic [COMPONENT_WIDTH-1:0] dir_ff [3];
   logic [COMPONENT_WIDTH-1:0] dir_in [3];
   logic                       zero_ff;
   carry_type                  out_carry;

   assign out_carry = dcarry_ff[COMPONENT_WIDTH-1];

   always_comb begin
      logic [COMPONENT_WIDTH-1:0] q;
      for (int n = 0; n < 3; n++) begin
         q = quo_ff[COMPONENT_WIDTH-1][n];
         if (out_carry.zero)              dir_in[n] = '0;
         else if (out_carry.neg[n])       dir_in[n] = -q;
         else if (q[COMPONENT_WIDTH-1])   dir_in[n] = DIR_MAX;
         else                             dir_in[n] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         for (int n = 0; n < 3; n++) dir_ff[n] <= dir_in[n];
         zero_ff <= out_carry.zero;
      end
   end

   // response word
   assign rsp_word.valid       = valid_ff[ST_OUT];
   assign rsp_word.dir_i       = dir_ff[0];
   assign rsp_word.dir_j       = dir_ff[1];
   assign rsp_word.dir_k       = dir_ff[2];
   assign rsp_word.zero_length = zero_ff;

endmodule

`default_nettype wire

[test/primary_ray_direction_tb.sv]
// self-checking testbench for the primary ray direction block
// drives screen points through prd_req_if, checks prd_rsp_if against a local predictor
// depends on prd_pkg, prd_req_if, prd_rsp_if and primary_ray_direction
`default_nettype none

module primary_ray_direction_tb;
   import prd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY     = 38 + COMPONENT_WIDTH;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_DIRECTED  = 16;

   // one expected direction word
   typedef struct packed {
      logic signed [COMPONENT_WIDTH-1:0] dir_i;
      logic signed [COMPONENT_WIDTH-1:0] dir_j;
      logic signed [COMPONENT_WIDTH-1:0] dir_k;
      logic                              zero_length;
   } direction_type;

   // one directed row: screen point, whether the result is typed in, and that result
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               typed;
      direction_type      dir;
   } point_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0]     csr_write_data = '0;

   prd_req_if req_word ();
   prd_rsp_if rsp_word ();

   primary_ray_direction uut (
      .clock(clock), .reset(reset),
      .req_word(req_word.sink), .rsp_word(rsp_word.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // clock, period 20 ns
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // camera copy held by the predictor
   logic [47:0] cam_forward, cam_right, cam_up;
   logic [15:0] cam_hscale, cam_vscale;

   direction_type expected_dirs[$];
   int  fail_count = 0;
   int  cycle_count = 0;
   int  result_count = 0;
   int  zero_count = 0;
   bit  quiet_phase = 0;
   bit  hold_rsp = 0;
   bit  long_hold = 0;
   bit  is_typed[$];
   direction_type typed_dirs[$];

   function automatic logic signed [63:0] lane_of(logic [47:0] v, int n);
      logic signed [15:0] l;
      l = v[47 - 16*n -: 16];
      return 64'(l);
   endfunction

   function automatic logic [63:0] root_of(logic [63:0] n);
      logic [63:0] res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      for (int it = 0; it < 32; it++) begin
         if (n >= res + bit_v) begin
            n = n - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // direction for one screen point under the current camera
   function automatic direction_type ray_direction(logic signed [15:0] x,
                                                   logic signed [15:0] y);
      logic signed [63:0] px, py, acc, s[3];
      logic [63:0] len2, r, mag, q;
      logic signed [63:0] maxp, minn;
      direction_type d;
      px = 64'(x) * $signed({48'd0, cam_hscale});
      py = 64'(y) * $signed({48'd0, cam_vscale});
      maxp = (64'sd1 <<< (COMPONENT_WIDTH-1)) - 1;
      minn = -(64'sd1 <<< (COMPONENT_WIDTH-1));
      len2 = 0;
      for (int n = 0; n < 3; n++) begin
         acc = lane_of(cam_forward, n) * (64'sd1 <<< 27) + lane_of(cam_right, n) * px
               + lane_of(cam_up, n) * py;
         acc = acc >>> 21;           // arithmetic shift floors
         if (acc > (64'sd1 <<< 25) - 1) acc = (64'sd1 <<< 25) - 1;
         if (acc < -(64'sd1 <<< 25)) acc = -(64'sd1 <<< 25);
         s[n] = acc;
         len2 = len2 + 64'(acc * acc);
      end
      d = '0;
      if (len2 == 0) begin
         d.zero_length = 1'b1;
         return d;
      end
      r = root_of(len2 << 10);
      for (int n = 0; n < 3; n++) begin
         logic signed [63:0] c;
         mag = (s[n] < 0) ? 64'(-s[n]) : 64'(s[n]);
         q = (mag << (COMPONENT_WIDTH - 1 + 5)) / r;
         if (s[n] < 0) c = (q > 64'(-minn)) ? minn : -$signed(q);
         else c = (q > 64'(maxp)) ? maxp : $signed(q);
         if (n == 0) d.dir_i = c[COMPONENT_WIDTH-1:0];
         else if (n == 1) d.dir_j = c[COMPONENT_WIDTH-1:0];
         else d.dir_k = c[COMPONENT_WIDTH-1:0];
      end
      return d;
   endfunction

   function automatic void camera_write(csr_index_type idx, logic [47:0] v);
      case (idx)
         CSR_FORWARD: cam_forward = v;
         CSR_RIGHT:   cam_right = v;
         CSR_UP:      cam_up = v;
         CSR_HSCALE:  cam_hscale = v[15:0];
         CSR_VSCALE:  cam_vscale = v[15:0];
         default: ;
      endcase
   endfunction

   // register write, at a falling edge, block idle
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [47:0] v);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v;
      if (idx <= CSR_VSCALE) camera_write(csr_index_type'(idx), v);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_dirs.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // offer one word, at times after a random gap outside the quiet phase, hold until taken
   task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                             bit typed, direction_type td);
      int gap;
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_word.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word.valid <= 1'b1;
      req_word.screen_x <= x;
      req_word.screen_y <= y;
      @(posedge clock);
      while (!req_word.ready) @(posedge clock);
      expected_dirs.push_back(ray_direction(x, y));
      is_typed.push_back(typed);
      typed_dirs.push_back(td);
      @(negedge clock);
   endtask

   task automatic send_random(int count);
      logic signed [15:0] x, y;
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(0, 3))
            0: begin x = 16'($urandom); y = 16'($urandom); end
            1: begin x = 16'($urandom_range(0, 1) ? 16'h8000 : 16'h7fff); y = 16'($urandom); end
            2: begin x = 16'($signed($urandom_range(0, 64)) - 32); y = 16'($urandom); end
            default: begin x = 16'($urandom); y = 16'($urandom_range(0, 1) ? 16'h8000 : 0); end
         endcase
         send_point(x, y, 1'b0, '0);
      end
      req_word.valid <= 1'b0;
   endtask

   function automatic logic [47:0] rand_basis();
      return {16'($urandom), 16'($urandom), 16'($urandom)};
   endfunction

   // receiver: random stalls, checks each word against the oldest expectation
   always @(negedge clock) begin
      if (reset || hold_rsp || long_hold) rsp_word.ready <= 1'b0;
      else if (quiet_phase) rsp_word.ready <= 1'b1;
      else rsp_word.ready <= ($urandom_range(0, 7) != 0);
   end

   // long burst-style stalls on the receiver side
   initial begin : stall_bursts
      int n;
      @(negedge reset);
      while (!quiet_phase) begin
         repeat ($urandom_range(20, 80)) @(negedge clock);
         if (quiet_phase) break;
         hold_rsp = 1;
         n = $urandom_range(1, 19);
         repeat (n) @(negedge clock);
         hold_rsp = 0;
      end
   end

   always @(posedge clock) begin
      direction_type exp_d, got;
      bit typed;
      direction_type td;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_word.valid && rsp_word.ready) begin
         got = {rsp_word.dir_i, rsp_word.dir_j, rsp_word.dir_k, rsp_word.zero_length};
         if (expected_dirs.size() == 0) begin
            $error("direction word with no expectation waiting");
            fail_count++;
         end else begin
            exp_d = expected_dirs.pop_front();
            typed = is_typed.pop_front();
            td = typed_dirs.pop_front();
            // typed rows must agree with the predictor too
            if (typed && td != exp_d) begin
               $error("typed row disagrees with predictor: %h vs %h", td, exp_d);
               fail_count++;
            end
            if (got.dir_i != exp_d.dir_i) begin
               $error("dir_i expected %0d actual %0d", exp_d.dir_i, got.dir_i); fail_count++;
            end
            if (got.dir_j != exp_d.dir_j) begin
               $error("dir_j expected %0d actual %0d", exp_d.dir_j, got.dir_j); fail_count++;
            end
            if (got.dir_k != exp_d.dir_k) begin
               $error("dir_k expected %0d actual %0d", exp_d.dir_k, got.dir_k); fail_count++;
            end
            if (got.zero_length != exp_d.zero_length) begin
               $error("zero_length expected %0d actual %0d", exp_d.zero_length,
                      got.zero_length);
               fail_count++;
            end
            result_count++;
            if (got.zero_length) zero_count++;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   localparam logic signed [15:0] PMAX = 16'sh7fff;
   localparam logic signed [15:0] PMIN = -16'sh8000;

   // directed points; the one typed row is the reset camera at the centre
   point_row_type point_table [N_DIRECTED] = '{
      '{16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 16'sh7fff, 1'b0}},
      '{PMAX, 16'sd0, 1'b0, '0},
      '{PMIN, 16'sd0, 1'b0, '0},
      '{16'sd0, PMAX, 1'b0, '0},
      '{16'sd0, PMIN, 1'b0, '0},
      '{PMAX, PMAX, 1'b0, '0},
      '{PMIN, PMIN, 1'b0, '0},
      '{PMAX, PMIN, 1'b0, '0},
      '{PMIN, PMAX, 1'b0, '0},
      '{16'sh5555, -16'sh2aab, 1'b0, '0},
      '{16'sd1, -16'sd1, 1'b0, '0},
      '{-16'sd1, 16'sd1, 1'b0, '0},
      '{16'sh4000, 16'sh4000, 1'b0, '0},
      '{-16'sh4000, 16'sh2000, 1'b0, '0},
      '{16'shaaaa, 16'sh5555, 1'b0, '0},
      '{16'sh0100, -16'sh0100, 1'b0, '0}
   };

   initial begin : stimulus
      cam_forward = 48'd16384;
      cam_right = 48'd16384 << 32;
      cam_up = 48'd16384 << 16;
      cam_hscale = 16'd4096;
      cam_vscale = 16'd4096;
      req_word.valid = 1'b0;
      req_word.screen_x = '0;
      req_word.screen_y = '0;
      rsp_word.ready = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table under the reset camera
      foreach (point_table[i])
         send_point(point_table[i].x, point_table[i].y, point_table[i].typed,
                    point_table[i].dir);
      req_word.valid <= 1'b0;
      wait_drained();

      // zero camera: every sum is zero; bad index ignored
      write_reg(CSR_FORWARD, 48'd0);
      write_reg(CSR_RIGHT, 48'd0);
      write_reg(CSR_UP, 48'd0);
      write_reg(3'd5, 48'hffff_ffff_ffff);
      write_reg(3'd7, 48'h1234_5678_9abc);
      send_point(PMAX, PMIN, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b1});
      send_point(PMIN, PMAX, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b1});
      req_word.valid <= 1'b0;
      wait_drained();

      // extreme registers: full scale, saturating sums
      write_reg(CSR_FORWARD, 48'h7fff_8000_7fff);
      write_reg(CSR_RIGHT, 48'h8000_7fff_8000);
      write_reg(CSR_UP, 48'hffff_ffff_ffff);
      write_reg(CSR_HSCALE, 48'hffff_ffff_ffff);
      write_reg(CSR_VSCALE, 48'hffff);
      send_random(150);
      wait_drained();

      // a zero horizontal scale and a small vertical scale
      write_reg(CSR_HSCALE, 48'd0);
      write_reg(CSR_VSCALE, 48'd1);
      send_random(100);
      wait_drained();

      // back-pressure: receiver holds off while the sender keeps offering
      write_reg(CSR_FORWARD, 48'd16384);
      write_reg(CSR_RIGHT, 48'd16384 << 32);
      write_reg(CSR_UP, 48'd16384 << 16);
      write_reg(CSR_HSCALE, 48'd4096);
      write_reg(CSR_VSCALE, 48'd4096);
      fork
         begin
            force_hold: begin
               @(negedge clock);
               long_hold = 1;
               repeat (300) @(negedge clock);
               long_hold = 0;
            end
         end
         send_random(150);
      join
      wait_drained();

      // random cameras
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(CSR_FORWARD, rand_basis());
         write_reg(CSR_RIGHT, rand_basis());
         write_reg(CSR_UP, rand_basis());
         write_reg(CSR_HSCALE, 48'($urandom));
         write_reg(CSR_VSCALE, 48'($urandom_range(0, 8192)));
         send_random(100);
         wait_drained();
      end

      // last part with no idling
      quiet_phase = 1;
      write_reg(CSR_FORWARD, rand_basis());
      write_reg(CSR_HSCALE, 48'($urandom));
      send_random(200);
      wait_drained();

      $display("covered %0d direction words, %0d of them zero length, over several cameras",
               result_count, zero_count);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
